[design/ifir_pkg.sv]
// ----------------------------------------------------------------------------
// ifir_pkg
// Shared types, constants and helpers of the dilated int8 FIR with requantizer.
// ----------------------------------------------------------------------------
package ifir_pkg;

   localparam int MAX_TAPS     = 8;
   localparam int MAX_DILATION = 4;
   localparam int HIST_DEPTH   = (MAX_TAPS - 1) * MAX_DILATION;
   localparam int FILL_MAX     = HIST_DEPTH + 1;
   localparam int FILL_W       = $clog2(FILL_MAX + 1);

   localparam int SMP_W      = 8;
   localparam int TAPS_W     = 4;
   localparam int DIL_W      = 3;
   localparam int BANK_W     = 64;
   localparam int BANK_IDX_W = $clog2(BANK_W / SMP_W);
   localparam int MULT_W     = 32;
   localparam int SHIFT_W    = 6;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;

   localparam int PRD_W = 2 * SMP_W;
   localparam int ACC_W = PRD_W + $clog2(MAX_TAPS);
   localparam int VAL_W = ACC_W + MULT_W;
   localparam int MAG_W = 64;
   localparam int SUM_W = VAL_W + 2;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
   localparam int NUM_STG   = 5;
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic signed [SMP_W-1:0] SAT_MAX = 8'sd127;
   localparam logic signed [SMP_W-1:0] SAT_MIN = -8'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_BANK    = 3'd0,
      CSR_TAP_COUNT   = 3'd1,
      CSR_DILATION    = 3'd2,
      CSR_SCALE_MULT  = 3'd3,
      CSR_SCALE_SHIFT = 3'd4,
      CSR_ZERO_POINT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [BANK_W-1:0]         tap_bank;
      logic [TAPS_W-1:0]         tap_count;
      logic [DIL_W-1:0]          dilation;
      logic signed [MULT_W-1:0]  scale_multiplier;
      logic [SHIFT_W-1:0]        scale_shift;
      logic signed [SMP_W-1:0]   zero_point;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      tap_bank:         '0,
      tap_count:        TAPS_W'(7),
      dilation:         DIL_W'(1),
      scale_multiplier: MULT_W'(1),
      scale_shift:      '0,
      zero_point:       '0
   };

   typedef struct packed {
      logic [MAX_TAPS-1:0][SMP_W-1:0] smp;
      logic                           last;
   } front_item_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] result;
      logic                    clipped;
      logic                    last;
   } rsp_item_type;

   function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] t);
      logic [TAPS_W-1:0] r;
      r = t;
      if (t == '0) r = TAPS_W'(1);
      if (t > TAPS_W'(MAX_TAPS)) r = TAPS_W'(MAX_TAPS);
      return r;
   endfunction

   function automatic logic [DIL_W-1:0] eff_dil(input logic [DIL_W-1:0] d);
      logic [DIL_W-1:0] r;
      r = d;
      if (d == '0) r = DIL_W'(1);
      if (d > DIL_W'(MAX_DILATION)) r = DIL_W'(MAX_DILATION);
      return r;
   endfunction

endpackage

[design/ifir_front.sv]
// ----------------------------------------------------------------------------
// ifir_front
// Keeps the sample delay line and the row fill count, decides whether an
// accepted sample produces a result and gathers the dilated window for it.
// ----------------------------------------------------------------------------
module ifir_front (
   input  logic                           clock,
   input  logic                           reset,
   input  ifir_pkg::cfg_type              cfg,
   input  logic                           accept,
   input  logic signed [ifir_pkg::SMP_W-1:0] sample,
   input  logic                           row_start,
   input  logic                           row_end,
   output logic                           q_push,
   output ifir_pkg::front_item_type       q_item
);

   logic [ifir_pkg::SMP_W-1:0]  hist_ff [ifir_pkg::HIST_DEPTH];
   logic [ifir_pkg::FILL_W-1:0] fill_ff;
   logic [ifir_pkg::FILL_W-1:0] fill_in;

   logic [ifir_pkg::FILL_W-1:0] fill_base;
   logic [ifir_pkg::FILL_W-1:0] span;
   logic [ifir_pkg::TAPS_W-1:0] taps;
   logic [ifir_pkg::DIL_W-1:0]  dil;
   logic                        emit;

   always_comb begin
      logic [ifir_pkg::SMP_W-1:0] sel;
      int                         span_i;
      taps      = ifir_pkg::eff_taps(cfg.tap_count);
      dil       = ifir_pkg::eff_dil(cfg.dilation);
      span_i    = (int'(taps) - 1) * int'(dil) + 1;
      span      = ifir_pkg::FILL_W'(span_i);
      fill_base = row_start ? '0 : fill_ff;
      fill_in   = (fill_base < ifir_pkg::FILL_W'(ifir_pkg::FILL_MAX)) ?
                  fill_base + ifir_pkg::FILL_W'(1) : fill_base;
      emit      = fill_in >= span;

      q_item.smp[0] = sample;
      for (int k = 1; k < ifir_pkg::MAX_TAPS; k++) begin
         sel = hist_ff[k-1];
         for (int d = 1; d <= ifir_pkg::MAX_DILATION; d++) begin
            if (dil == ifir_pkg::DIL_W'(d)) begin
               sel = hist_ff[k*d-1];
            end
         end
         q_item.smp[k] = sel;
      end
      q_item.last = row_end;
      q_push      = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ifir_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (accept) begin
         hist_ff[0] <= sample;
         for (int i = 1; i < ifir_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

[design/ifir_queue.sv]
// ----------------------------------------------------------------------------
// ifir_queue
// Short show-ahead queue of gathered windows between front and back end.
// ----------------------------------------------------------------------------
module ifir_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ifir_pkg::front_item_type din,
   input  logic                     pop,
   output ifir_pkg::front_item_type dout,
   output logic                     full,
   output logic                     empty
);

   ifir_pkg::front_item_type        mem_ff [ifir_pkg::Q_DEPTH];
   logic [ifir_pkg::Q_PTR_W-1:0]    wr_ptr_ff;
   logic [ifir_pkg::Q_PTR_W-1:0]    rd_ptr_ff;
   logic [ifir_pkg::Q_CNT_W-1:0]    cnt_ff;
   logic                            do_push;
   logic                            do_pop;

   assign full    = cnt_ff == ifir_pkg::Q_CNT_W'(ifir_pkg::Q_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + ifir_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + ifir_pkg::Q_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + ifir_pkg::Q_CNT_W'(1);
         end else if (!do_push && do_pop) begin
            cnt_ff <= cnt_ff - ifir_pkg::Q_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[design/ifir_back.sv]
// ----------------------------------------------------------------------------
// ifir_back
// Multiply-accumulate and requantization pipeline with its result queue.
// Windows are taken only while the result queue has room for everything
// in flight.
// ----------------------------------------------------------------------------
module ifir_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ifir_pkg::cfg_type                   cfg,
   input  logic                                q_empty,
   input  ifir_pkg::front_item_type            q_item,
   output logic                                q_pop,
   input  logic                                pop,
   output logic                                empty,
   output logic signed [ifir_pkg::SMP_W-1:0]   rsp_result,
   output logic                                rsp_clipped,
   output logic                                rsp_last_output
);

   logic [ifir_pkg::NUM_STG-1:0]          vld_ff;
   logic [ifir_pkg::NUM_STG-1:0]          last_ff;
   logic signed [ifir_pkg::PRD_W-1:0]     prod_ff [ifir_pkg::MAX_TAPS];
   logic signed [ifir_pkg::ACC_W-1:0]     acc_ff;
   logic signed [ifir_pkg::VAL_W-1:0]     val_ff;
   logic                                  neg_ff [3:4];
   logic [ifir_pkg::MAG_W-1:0]            mag_ff;
   logic [ifir_pkg::MAG_W-1:0]            rmag_ff;

   ifir_pkg::rsp_item_type                out_mem_ff [ifir_pkg::OUT_DEPTH];
   logic [ifir_pkg::OUT_PTR_W-1:0]        wr_ptr_ff;
   logic [ifir_pkg::OUT_PTR_W-1:0]        rd_ptr_ff;
   logic [ifir_pkg::OUT_CNT_W-1:0]        cnt_ff;

   logic signed [ifir_pkg::SMP_W-1:0]     wgt [ifir_pkg::MAX_TAPS];
   logic signed [ifir_pkg::ACC_W-1:0]     acc_in;
   logic signed [ifir_pkg::VAL_W-1:0]     vabs;
   logic [ifir_pkg::MAG_W-1:0]            half;
   logic signed [ifir_pkg::SUM_W-1:0]     sum;
   ifir_pkg::rsp_item_type                wr_item;
   logic                                  do_wr;
   logic                                  do_rd;

   always_comb begin
      logic [ifir_pkg::TAPS_W-1:0]      taps;
      int                               idx;
      logic signed [ifir_pkg::VAL_W:0]  rs;
      taps = ifir_pkg::eff_taps(cfg.tap_count);
      for (int k = 0; k < ifir_pkg::MAX_TAPS; k++) begin
         idx    = int'(taps) - 1 - k;
         wgt[k] = '0;
         if (k < int'(taps)) begin
            wgt[k] = cfg.tap_bank[ifir_pkg::SMP_W*idx[ifir_pkg::BANK_IDX_W-1:0]
                                  +: ifir_pkg::SMP_W];
         end
      end

      acc_in = '0;
      for (int k = 0; k < ifir_pkg::MAX_TAPS; k++) begin
         acc_in = acc_in + ifir_pkg::ACC_W'(prod_ff[k]);
      end

      vabs = val_ff[ifir_pkg::VAL_W-1] ? -val_ff : val_ff;
      half = (cfg.scale_shift == '0) ? '0 :
             ifir_pkg::MAG_W'(1) << (cfg.scale_shift - ifir_pkg::SHIFT_W'(1));

      rs  = $signed({1'b0, rmag_ff[ifir_pkg::VAL_W-1:0]});
      if (neg_ff[4]) begin
         rs = -rs;
      end
      sum = ifir_pkg::SUM_W'(rs) + ifir_pkg::SUM_W'(cfg.zero_point);
      wr_item.last    = last_ff[ifir_pkg::NUM_STG-1];
      wr_item.clipped = 1'b1;
      if (sum > ifir_pkg::SUM_W'(ifir_pkg::SAT_MAX)) begin
         wr_item.result = ifir_pkg::SAT_MAX;
      end else if (sum < ifir_pkg::SUM_W'(ifir_pkg::SAT_MIN)) begin
         wr_item.result = ifir_pkg::SAT_MIN;
      end else begin
         wr_item.result  = sum[ifir_pkg::SMP_W-1:0];
         wr_item.clipped = 1'b0;
      end
   end

   assign q_pop = !q_empty &&
                  ((int'(cnt_ff) + int'($countones(vld_ff))) < ifir_pkg::OUT_DEPTH);
   assign do_wr = vld_ff[ifir_pkg::NUM_STG-1];
   assign do_rd = pop && !empty;
   assign empty = cnt_ff == '0;
   assign rsp_result      = out_mem_ff[rd_ptr_ff].result;
   assign rsp_clipped     = out_mem_ff[rd_ptr_ff].clipped;
   assign rsp_last_output = out_mem_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ifir_pkg::NUM_STG-2:0], q_pop};
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= {last_ff[ifir_pkg::NUM_STG-2:0], q_item.last};
      for (int k = 0; k < ifir_pkg::MAX_TAPS; k++) begin
         prod_ff[k] <= $signed(q_item.smp[k]) * wgt[k];
      end
      acc_ff    <= acc_in;
      val_ff    <= acc_ff * cfg.scale_multiplier;
      neg_ff[3] <= val_ff[ifir_pkg::VAL_W-1];
      mag_ff    <= {{(ifir_pkg::MAG_W-ifir_pkg::VAL_W){1'b0}}, vabs};
      neg_ff[4] <= neg_ff[3];
      rmag_ff   <= (mag_ff + half) >> cfg.scale_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + ifir_pkg::OUT_PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + ifir_pkg::OUT_PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + ifir_pkg::OUT_CNT_W'(1);
         end else if (!do_wr && do_rd) begin
            cnt_ff <= cnt_ff - ifir_pkg::OUT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         out_mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[design/int8_dilated_fir_requant_top.sv]
// ----------------------------------------------------------------------------
// int8_dilated_fir_requant_top
// Dilated int8 FIR with requantization: front end, window queue, MAC back end.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the window queue is not full, set by
// the 5-stage MAC/requant pipeline and the 8-entry result queue that credits it.
// Reset (synchronous): clears row fill, delay line, queues and pipeline
// valid bits, and loads register defaults.
module int8_dilated_fir_requant_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [ifir_pkg::SMP_W-1:0]    req_sample,
   input  logic                                 req_row_start,
   input  logic                                 req_row_end,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [ifir_pkg::SMP_W-1:0]    rsp_result,
   output logic                                 rsp_clipped,
   output logic                                 rsp_last_output,
   input  logic                                 csr_wr_en,
   input  logic [ifir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ifir_pkg::CSR_W-1:0]           csr_wdata
);

   ifir_pkg::cfg_type         cfg_ff;
   ifir_pkg::front_item_type  f_item;
   ifir_pkg::front_item_type  q_item;
   logic                      f_push;
   logic                      q_pop;
   logic                      q_empty;
   logic                      accept;

   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ifir_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         case (ifir_pkg::csr_index_type'(csr_index))
            ifir_pkg::CSR_TAP_BANK: begin
               cfg_ff.tap_bank <= csr_wdata[ifir_pkg::BANK_W-1:0];
            end
            ifir_pkg::CSR_TAP_COUNT: begin
               cfg_ff.tap_count <= csr_wdata[ifir_pkg::TAPS_W-1:0];
            end
            ifir_pkg::CSR_DILATION: begin
               cfg_ff.dilation <= csr_wdata[ifir_pkg::DIL_W-1:0];
            end
            ifir_pkg::CSR_SCALE_MULT: begin
               cfg_ff.scale_multiplier <= csr_wdata[ifir_pkg::MULT_W-1:0];
            end
            ifir_pkg::CSR_SCALE_SHIFT: begin
               cfg_ff.scale_shift <= csr_wdata[ifir_pkg::SHIFT_W-1:0];
            end
            ifir_pkg::CSR_ZERO_POINT: begin
               cfg_ff.zero_point <= csr_wdata[ifir_pkg::SMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   ifir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .sample    (req_sample),
      .row_start (req_row_start),
      .row_end   (req_row_end),
      .q_push    (f_push),
      .q_item    (f_item)
   );

   ifir_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   (f_item),
      .pop   (q_pop),
      .dout  (q_item),
      .full  (full),
      .empty (q_empty)
   );

   ifir_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_result      (rsp_result),
      .rsp_clipped     (rsp_clipped),
      .rsp_last_output (rsp_last_output)
   );

endmodule

[design/ifir_checker.sv]
// ----------------------------------------------------------------------------
// ifir_checker
// Port-level checks for the dilated FIR top level, bound to it below.
// ----------------------------------------------------------------------------
module ifir_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic                                 full,
   input  logic signed [ifir_pkg::SMP_W-1:0]    req_sample,
   input  logic                                 req_row_start,
   input  logic                                 req_row_end,
   input  logic                                 empty,
   input  logic                                 pop,
   input  logic signed [ifir_pkg::SMP_W-1:0]    rsp_result,
   input  logic                                 rsp_clipped,
   input  logic                                 rsp_last_output,
   input  logic                                 csr_wr_en,
   input  logic [ifir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ifir_pkg::CSR_W-1:0]           csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{push, req_sample, req_row_start, req_row_end,
                        csr_wr_en, csr_index, csr_wdata};

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not cleared by reset");

   a_clip_rails: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_clipped |->
         rsp_result == ifir_pkg::SAT_MAX || rsp_result == ifir_pkg::SAT_MIN)
      else $error("clipped transaction not at a saturation rail");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> !$past(reset, 2) && !$past(reset, 3))
      else $error("result transaction appeared too soon after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_result) && $stable(rsp_clipped)
         && $stable(rsp_last_output))
      else $error("stalled result transaction changed");

endmodule

bind int8_dilated_fir_requant_top ifir_checker u_checker (.*);
